@@ rtl/tilt_calibrate_and_throttle_map_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the tilt calibration and throttle map unit
// Each check is sampled on clk; the plain form is disabled during rst.
// ----------------------------------------------------------------------------
`ifndef TILT_CALIBRATE_AND_THROTTLE_MAP_UNIT_ASSERT_SVH
`define TILT_CALIBRATE_AND_THROTTLE_MAP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// check outside reset
`define TCATM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tcatm assertion failed");

// check that also holds during reset
`define TCATM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tcatm assertion failed");

`else

`define TCATM_ASSERT(label, prop)
`define TCATM_ASSERT_ALWAYS(label, prop)

`endif

`endif

@@ rtl/tcatm_pkg.sv @@
// ----------------------------------------------------------------------------
// tcatm_pkg
// Shared constants, step codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tcatm_pkg;

  localparam int SAMPLE_BITS_DEFAULT = 16;

  // extra numerator bits for |x| * 50
  localparam int NUM_EXTRA_BITS = 5;

  localparam int NEUTRAL    = 50;
  localparam int DEAD_HIGH  = 55;
  localparam int DEAD_LOW   = 45;
  localparam int FULL_SCALE = 100;

  localparam logic [2:0] STEP_ZERO     = 3'd0;
  localparam logic [2:0] STEP_FORWARD  = 3'd1;
  localparam logic [2:0] STEP_BACKWARD = 3'd2;
  localparam logic [2:0] STEP_LEFT     = 3'd3;
  localparam logic [2:0] STEP_RIGHT    = 3'd4;
  localparam logic [2:0] STEP_DONE     = 3'd5;

  // bit0 red, bit1 green, bit2 blue
  localparam logic [2:0] LED_OFF    = 3'b000;
  localparam logic [2:0] LED_YELLOW = 3'b011;
  localparam logic [2:0] LED_PURPLE = 3'b101;
  localparam logic [2:0] LED_CYAN   = 3'b110;
  localparam logic [2:0] LED_WHITE  = 3'b111;

  typedef struct packed {
    logic load;      // input beat accepted this cycle
    logic step;      // one divider iteration
    logic out_load;  // result into output register
  } tcatm_cmd_t;

  typedef struct packed {
    logic need_div;  // accepted beat needs the divider
    logic out_free;  // output register can take a result
  } tcatm_status_t;

  function automatic logic [2:0] led_for_step(input logic [2:0] step);
    logic [2:0] led;
    unique case (step)
      STEP_FORWARD:  led = LED_YELLOW;
      STEP_BACKWARD: led = LED_PURPLE;
      STEP_LEFT:     led = LED_CYAN;
      STEP_DONE:     led = LED_WHITE;
      default:       led = LED_OFF;
    endcase
    return led;
  endfunction

endpackage

@@ rtl/tcatm_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcatm_ctrl
// Sequencer: accept, divider iterations, result hand-off.
// ----------------------------------------------------------------------------
`include "tilt_calibrate_and_throttle_map_unit_assert.svh"

module tcatm_ctrl #(
  parameter int DIV_STEPS = tcatm_pkg::SAMPLE_BITS_DEFAULT + tcatm_pkg::NUM_EXTRA_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  tcatm_pkg::tcatm_status_t status,
  output tcatm_pkg::tcatm_cmd_t    cmd
);
  import tcatm_pkg::*;

  localparam int CNT_BITS = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_STEPS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } state_t;

  state_t              state;
  logic [CNT_BITS-1:0] cnt;

  assign in_stall     = (state != S_IDLE);
  assign cmd.load     = (state == S_IDLE) && in_valid;
  assign cmd.step     = (state == S_DIV);
  assign cmd.out_load = (state == S_FIN) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (in_valid) begin
            state <= status.need_div ? S_DIV : S_FIN;
          end
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TCATM_ASSERT(a_load_leaves_idle, cmd.load |=> (state != S_IDLE))
  `TCATM_ASSERT(a_div_ends_in_fin, (state == S_DIV && cnt == CNT_LAST) |=> (state == S_FIN))
  `TCATM_ASSERT(a_fin_waits_for_out, (state == S_FIN && !status.out_free) |=> (state == S_FIN))

endmodule

@@ rtl/tcatm_datapath.sv @@
// ----------------------------------------------------------------------------
// tcatm_datapath
// Calibration state, peak capture, restoring divider, clamp, output register.
// ----------------------------------------------------------------------------
`include "tilt_calibrate_and_throttle_map_unit_assert.svh"

module tcatm_datapath #(
  parameter int SAMPLE_BITS = tcatm_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tcatm_pkg::tcatm_cmd_t    cmd,
  output tcatm_pkg::tcatm_status_t status,
  input  logic signed [15:0]       tilt_x,
  input  logic                     button_press,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [6:0]               drive_percent,
  output logic                     drive_valid,
  output logic [2:0]               calibration_step,
  output logic [2:0]               led_pattern,
  output logic                     divide_fault
);
  import tcatm_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int NB = SAMPLE_BITS + NUM_EXTRA_BITS;
  localparam int VB = NB + 2;

  localparam logic signed [VB-1:0] V_NEUTRAL = VB'(NEUTRAL);
  localparam logic signed [VB-1:0] V_HIGH    = VB'(DEAD_HIGH);
  localparam logic signed [VB-1:0] V_LOW     = VB'(DEAD_LOW);
  localparam logic signed [VB-1:0] V_FULL    = VB'(FULL_SCALE);

  typedef enum logic [1:0] {
    K_NEUTRAL,
    K_RAW,
    K_PLUS,
    K_MINUS
  } kind_t;

  logic [2:0]    phase;
  logic [SB-1:0] fwd_peak;
  logic [SB-1:0] bwd_peak;

  logic [SB-1:0] x_r;
  logic [SB-1:0] div_r;
  logic [SB-1:0] rem;
  logic [NB-1:0] quo;
  kind_t         kind_r;
  logic          mapped_r;
  logic          fault_r;

  // ---- decode at accept ----
  logic [SB-1:0] x_in;
  logic          x_neg, x_zero;
  logic [SB-1:0] x_mag, f_mag, b_mag;
  logic [NB-1:0] num;
  logic          f_neg, f_zero, b_neg, b_zero;
  logic          mapped;
  kind_t         kind;
  logic          fault;
  logic [SB-1:0] divisor;

  always_comb begin
    x_in   = tilt_x[SB-1:0];
    x_neg  = x_in[SB-1];
    x_zero = (x_in == '0);
    x_mag  = x_neg ? (~x_in + 1'b1) : x_in;
    // |x| * 50 = 32|x| + 16|x| + 2|x|
    num    = NB'({x_mag, 5'b0}) + NB'({x_mag, 4'b0}) + NB'({x_mag, 1'b0});
    f_neg  = fwd_peak[SB-1];
    f_zero = (fwd_peak == '0);
    f_mag  = f_neg ? (~fwd_peak + 1'b1) : fwd_peak;
    b_neg  = bwd_peak[SB-1];
    b_zero = (bwd_peak == '0);
    b_mag  = b_neg ? (~bwd_peak + 1'b1) : bwd_peak;
    mapped = (phase >= STEP_DONE);

    fault   = 1'b0;
    divisor = f_mag;
    if (x_zero) begin
      kind = K_NEUTRAL;
    end else if (f_zero) begin
      kind = K_RAW;
    end else if (x_neg == f_neg) begin
      kind = K_PLUS;
    end else if (b_zero) begin
      kind  = K_NEUTRAL;
      fault = 1'b1;
    end else begin
      divisor = b_mag;
      kind    = (x_neg != b_neg) ? K_PLUS : K_MINUS;
    end
  end

  assign status.need_div = mapped && (kind == K_PLUS || kind == K_MINUS);
  assign status.out_free = !out_valid || !out_stall;

  // ---- restoring divider step ----
  logic [SB:0] trial;
  logic        fits;

  always_comb begin
    trial = {rem, quo[NB-1]};
    fits  = (trial >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= STEP_ZERO;
      fwd_peak <= '0;
      bwd_peak <= '0;
    end else if (cmd.load) begin
      if (mapped) begin
        phase <= STEP_DONE;
      end else if (button_press) begin
        if (phase == STEP_FORWARD) begin
          fwd_peak <= x_in;
        end else if (phase == STEP_BACKWARD) begin
          bwd_peak <= x_in;
        end
        phase <= phase + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r      <= x_in;
      div_r    <= divisor;
      rem      <= '0;
      quo      <= num;
      kind_r   <= kind;
      mapped_r <= mapped;
      fault_r  <= mapped && fault;
    end else if (cmd.step) begin
      if (fits) begin
        rem <= SB'(trial - {1'b0, div_r});
      end else begin
        rem <= trial[SB-1:0];
      end
      quo <= {quo[NB-2:0], fits};
    end
  end

  // ---- offset, dead zone, clamp ----
  logic signed [VB-1:0] q_wide;
  logic signed [VB-1:0] v_wide;
  logic [6:0]           pct;

  always_comb begin
    q_wide = signed'({2'b00, quo});
    case (kind_r)
      K_PLUS:  v_wide = V_NEUTRAL + q_wide;
      K_MINUS: v_wide = V_NEUTRAL - q_wide;
      K_RAW:   v_wide = signed'({{(VB-SB){x_r[SB-1]}}, x_r});
      default: v_wide = V_NEUTRAL;
    endcase

    if (v_wide > V_NEUTRAL && v_wide < V_HIGH) begin
      pct = 7'(NEUTRAL);
    end else if (v_wide < V_NEUTRAL && v_wide > V_LOW) begin
      pct = 7'(NEUTRAL);
    end else if (v_wide < 0) begin
      pct = 7'd0;
    end else if (v_wide > V_FULL) begin
      pct = 7'(FULL_SCALE);
    end else begin
      pct = v_wide[6:0];
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      drive_percent    <= mapped_r ? pct : 7'd0;
      drive_valid      <= mapped_r;
      calibration_step <= phase;
      led_pattern      <= led_for_step(phase);
      divide_fault     <= fault_r;
    end
  end

  `TCATM_ASSERT(a_mapped_only_when_done,
    (out_valid && drive_valid) |-> (phase == STEP_DONE))
  `TCATM_ASSERT(a_percent_in_range,
    (out_valid && drive_valid) |-> (drive_percent <= 7'(FULL_SCALE)))

endmodule

@@ rtl/tilt_calibrate_and_throttle_map_unit.sv @@
// ----------------------------------------------------------------------------
// tilt_calibrate_and_throttle_map_unit
// Tilt calibration sequencer and forward/backward throttle mapper.
// ----------------------------------------------------------------------------
// One input beat (tilt_x, tilt_y, button_press) gives exactly one result
// beat. After reset the unit steps through zero, forward, backward, left and
// right; a press advances the step, the forward press stores tilt_x as the
// forward peak and the backward press stores it as the backward peak. Once
// done, each beat maps tilt_x to drive_percent 0..100 (50 neutral): the
// magnitude |x|*50 is divided by the matching peak, a dead zone snaps 46..54
// to 50 and the result is clamped. A zero backward divisor gives 50 with
// divide_fault set; a zero forward peak passes x unscaled to the clamp.
// Only the low SAMPLE_BITS bits of tilt_x are used; tilt_y is not used.
// Calibration beats and mapped beats that need no division go from accept
// straight to the result hand-off; a mapped beat that divides first runs
// the restoring divider, which retires one quotient bit per cycle over
// SAMPLE_BITS + 5 bits. One beat is in flight at a time; the output
// register lets a new beat be accepted while the previous result still
// waits on out_stall.

module tilt_calibrate_and_throttle_map_unit #(
  parameter int SAMPLE_BITS = tcatm_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] tilt_x,
  input  logic signed [15:0] tilt_y,
  input  logic               button_press,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         drive_percent,
  output logic               drive_valid,
  output logic [2:0]         calibration_step,
  output logic [2:0]         led_pattern,
  output logic               divide_fault
);
  import tcatm_pkg::*;

  // one divider iteration per quotient bit of |x|*50
  localparam int DIV_STEPS = SAMPLE_BITS + NUM_EXTRA_BITS;

  tcatm_cmd_t    cmd;
  tcatm_status_t status;

  tcatm_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // tilt_y rides along on the channel; the mapping ignores it
  tcatm_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .tilt_x           (tilt_x),
    .button_press     (button_press),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .drive_percent    (drive_percent),
    .drive_valid      (drive_valid),
    .calibration_step (calibration_step),
    .led_pattern      (led_pattern),
    .divide_fault     (divide_fault)
  );

endmodule
